// ===== src/grid_laplacian_smooth_macros.svh =====
// Assertion macros shared by the grid smoothing RTL.
`ifndef GRID_LAPLACIAN_SMOOTH_MACROS_SVH
`define GRID_LAPLACIAN_SMOOTH_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define GLS_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The condition must hold in the cycle after the trigger.
`define GLS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/gls_pkg.sv =====
// Shared types, constants and helper functions of the grid smoothing block.
`default_nettype none
package gls_pkg;

   localparam int MaxPointsDef = 4096;
   localparam int MaxDimDef    = 64;
   localparam int FracBits     = 8;
   localparam int CoordW       = 32;
   localparam int SumW         = 34;
   localparam int NumW         = 36;
   localparam int DivW         = 37;
   localparam int KW           = 3;
   localparam int CntW         = 6;

   localparam logic signed [CoordW-1:0] MinusOne = CoordW'(-(1 << FracBits));

   typedef struct packed {
      logic signed [CoordW-1:0] z;
      logic signed [CoordW-1:0] y;
      logic signed [CoordW-1:0] x;
      logic                     vld;
   } point_type;

   typedef enum logic [1:0] {
      RegRows   = 2'd0,
      RegCols   = 2'd1,
      RegPasses = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic start;
      logic src_bank;
   } pass_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } pass_stat_type;

   function automatic logic point_ok(point_type p);
      return p.vld && (p.x != MinusOne) && (p.y != MinusOne) && (p.z != MinusOne);
   endfunction

endpackage
`default_nettype wire

// ===== src/gls_store.sv =====
// Point memory with one write port and one registered read port.
`default_nettype none
module gls_store
   import gls_pkg::*;
#(
   parameter int Depth = 2 * MaxPointsDef,
   localparam int AW = $clog2(Depth)
) (
   input  wire logic      clock,
   input  wire logic      wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire point_type wr_data,
   input  wire logic      rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output point_type      rd_data
);

   point_type store_ff [Depth];
   point_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== src/gls_div.sv =====
// Bit-serial floor division of half the blend numerator by the neighbor count.
`default_nettype none
module gls_div
   import gls_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic signed [NumW-1:0] num,
   input  wire logic [KW-1:0]          k,
   output logic                        busy,
   output logic [CoordW-1:0]           quo
);

   logic signed [DivW-1:0] half;
   logic [DivW-1:0]        shifted;
   logic [DivW-1:0]        acc_ff, acc_in;
   logic [KW-1:0]          rem_ff, rem_in;
   logic [KW-1:0]          k_ff, k_in;
   logic [CoordW-1:0]      quo_ff, quo_in;
   logic [CntW-1:0]        cnt_ff, cnt_in;
   logic [KW:0]            rem2;
   logic                   ge;

   // The offset k * 2^34 keeps the dividend positive and leaves the low quotient bits intact.
   assign half    = $signed({num[NumW-1], num}) >>> 1;
   assign shifted = unsigned'(half) + {k, (DivW-KW)'(0)};
   assign rem2    = {rem_ff, acc_ff[DivW-1]};
   assign ge      = rem2 >= {1'b0, k_ff};

   always_comb begin
      acc_in = acc_ff;
      rem_in = rem_ff;
      k_in   = k_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      if (start) begin
         acc_in = shifted;
         rem_in = '0;
         k_in   = k;
         cnt_in = CntW'(DivW);
      end else if (cnt_ff != '0) begin
         acc_in = acc_ff << 1;
         rem_in = ge ? KW'(rem2 - {1'b0, k_ff}) : rem2[KW-1:0];
         quo_in = {quo_ff[CoordW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      k_ff   <= k_in;
      quo_ff <= quo_in;
   end

   assign busy = cnt_ff != '0;
   assign quo  = quo_ff;

endmodule
`default_nettype wire

// ===== src/gls_pass.sv =====
// Sequencer for one smoothing pass: fetches each point and its neighbors, blends, writes back.
`default_nettype none
module gls_pass
   import gls_pkg::*;
#(
   parameter int MaxPoints = MaxPointsDef,
   parameter int MaxDim    = MaxDimDef,
   localparam int IW = $clog2(MaxPoints + 1),
   localparam int AW = $clog2(2 * MaxPoints),
   localparam int DW = $clog2(MaxDim + 1)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire pass_ctl_type  ctl,
   input  wire logic [DW-1:0] rows,
   input  wire logic [DW-1:0] cols,
   input  wire logic [IW-1:0] npts,
   output logic               rd_en,
   output logic [AW-1:0]      rd_addr,
   input  wire point_type     rd_data,
   output logic               wr_en,
   output logic [AW-1:0]      wr_addr,
   output point_type          wr_data,
   output pass_stat_type      stat
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_FETCH = 6'b000010,
      ST_NUM   = 6'b000100,
      ST_DIV   = 6'b001000,
      ST_WAIT  = 6'b010000,
      ST_WRITE = 6'b100000
   } state_type;

   localparam logic [2:0] SlotCenter = 3'd0;
   localparam logic [2:0] SlotUp     = 3'd1;
   localparam logic [2:0] SlotDown   = 3'd2;
   localparam logic [2:0] SlotLeft   = 3'd3;
   localparam logic [2:0] SlotRight  = 3'd4;
   localparam logic [2:0] SlotEnd    = 3'd5;

   state_type              state_ff, state_in;
   logic [IW-1:0]          idx_ff, idx_in;
   logic [DW-1:0]          row_ff, row_in;
   logic [DW-1:0]          col_ff, col_in;
   logic [2:0]             slot_ff, slot_in;
   logic                   bank_ff, bank_in;
   logic                   mask_ff, mask_in;
   point_type              cur_ff, cur_in;
   logic                   cur_ok_ff, cur_ok_in;
   logic signed [SumW-1:0] sx_ff, sx_in, sy_ff, sy_in, sz_ff, sz_in;
   logic [KW-1:0]          k_ff, k_in;
   logic signed [NumW-1:0] nx_ff, nx_in, ny_ff, ny_in, nz_ff, nz_in;
   logic signed [NumW-1:0] k_wide;
   logic [IW-1:0]          nb_idx;
   logic                   in_grid;
   logic                   div_start;
   logic                   done;
   logic                   busy_x, busy_y, busy_z;
   logic [CoordW-1:0]      qx, qy, qz;

   assign k_wide = NumW'(k_ff);

   always_comb begin
      nb_idx  = idx_ff;
      in_grid = 1'b1;
      unique case (slot_ff)
         SlotCenter: in_grid = 1'b1;
         SlotUp: begin
            in_grid = row_ff != '0;
            nb_idx  = idx_ff - IW'(cols);
         end
         SlotDown: begin
            in_grid = row_ff != DW'(rows - 1'b1);
            nb_idx  = idx_ff + IW'(cols);
         end
         SlotLeft: begin
            in_grid = col_ff != '0;
            nb_idx  = idx_ff - 1'b1;
         end
         SlotRight: begin
            in_grid = col_ff != DW'(cols - 1'b1);
            nb_idx  = idx_ff + 1'b1;
         end
         default: in_grid = 1'b0;
      endcase
      if (!in_grid) begin
         nb_idx = idx_ff;
      end
   end

   assign rd_en   = (state_ff == ST_FETCH) && (slot_ff < SlotEnd);
   assign rd_addr = bank_ff ? AW'(nb_idx) + AW'(MaxPoints) : AW'(nb_idx);
   assign wr_addr = bank_ff ? AW'(idx_ff) : AW'(idx_ff) + AW'(MaxPoints);

   always_comb begin
      if (!cur_ok_ff) begin
         wr_data = '{z: MinusOne, y: MinusOne, x: MinusOne, vld: 1'b0};
      end else if (k_ff == '0) begin
         wr_data = '{z: cur_ff.z, y: cur_ff.y, x: cur_ff.x, vld: 1'b1};
      end else begin
         wr_data = '{z: qz, y: qy, x: qx, vld: 1'b1};
      end
   end

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      slot_in   = slot_ff;
      bank_in   = bank_ff;
      mask_in   = mask_ff;
      cur_in    = cur_ff;
      cur_ok_in = cur_ok_ff;
      sx_in     = sx_ff;
      sy_in     = sy_ff;
      sz_in     = sz_ff;
      k_in      = k_ff;
      nx_in     = nx_ff;
      ny_in     = ny_ff;
      nz_in     = nz_ff;
      div_start = 1'b0;
      wr_en     = 1'b0;
      done      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               state_in = ST_FETCH;
               idx_in   = '0;
               row_in   = '0;
               col_in   = '0;
               slot_in  = SlotCenter;
               bank_in  = ctl.src_bank;
               sx_in    = '0;
               sy_in    = '0;
               sz_in    = '0;
               k_in     = '0;
            end
         end
         ST_FETCH: begin
            mask_in = in_grid;
            slot_in = slot_ff + 1'b1;
            if (slot_ff == SlotUp) begin
               cur_in    = rd_data;
               cur_ok_in = point_ok(rd_data);
            end else if (slot_ff != SlotCenter && mask_ff && point_ok(rd_data)) begin
               sx_in = sx_ff + SumW'(rd_data.x);
               sy_in = sy_ff + SumW'(rd_data.y);
               sz_in = sz_ff + SumW'(rd_data.z);
               k_in  = k_ff + 1'b1;
            end
            if (slot_ff == SlotEnd) begin
               state_in = ST_NUM;
            end
         end
         ST_NUM: begin
            nx_in = NumW'(cur_ff.x) * k_wide + NumW'(sx_ff) + k_wide;
            ny_in = NumW'(cur_ff.y) * k_wide + NumW'(sy_ff) + k_wide;
            nz_in = NumW'(cur_ff.z) * k_wide + NumW'(sz_ff) + k_wide;
            if (!cur_ok_ff || k_ff == '0) begin
               state_in = ST_WRITE;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            div_start = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (!(busy_x || busy_y || busy_z)) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            wr_en = 1'b1;
            if (idx_ff == IW'(npts - 1'b1)) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_FETCH;
               idx_in   = idx_ff + 1'b1;
               slot_in  = SlotCenter;
               sx_in    = '0;
               sy_in    = '0;
               sz_in    = '0;
               k_in     = '0;
               if (col_ff == DW'(cols - 1'b1)) begin
                  col_in = '0;
                  row_in = row_ff + 1'b1;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      idx_ff    <= idx_in;
      row_ff    <= row_in;
      col_ff    <= col_in;
      slot_ff   <= slot_in;
      bank_ff   <= bank_in;
      mask_ff   <= mask_in;
      cur_ff    <= cur_in;
      cur_ok_ff <= cur_ok_in;
      sx_ff     <= sx_in;
      sy_ff     <= sy_in;
      sz_ff     <= sz_in;
      k_ff      <= k_in;
      nx_ff     <= nx_in;
      ny_ff     <= ny_in;
      nz_ff     <= nz_in;
   end

   gls_div u_div_x (.clock, .reset, .start(div_start), .num(nx_ff), .k(k_ff),
                    .busy(busy_x), .quo(qx));
   gls_div u_div_y (.clock, .reset, .start(div_start), .num(ny_ff), .k(k_ff),
                    .busy(busy_y), .quo(qy));
   gls_div u_div_z (.clock, .reset, .start(div_start), .num(nz_ff), .k(k_ff),
                    .busy(busy_z), .quo(qz));

   assign stat.busy = state_ff != ST_IDLE;
   assign stat.done = done;

endmodule
`default_nettype wire

// ===== src/grid_laplacian_smooth.sv =====
// Top level of the grid smoothing block: register port, request handling and pass control.
// Load requests (tuser 0) fill the grid in row-major order and are taken one per cycle while
// no response waits; read requests (tuser 1) return stored points in row-major order through
// the registered memory read followed by the output register; no request is taken while a
// read is pending. The load that completes the grid starts pass_count smoothing passes over
// two ping-pong banks in one memory with a single read port; during the passes no request is
// taken. Each point needs five memory reads, and a point with valid neighbors also waits for
// a 37-step bit-serial divide. The memory needs no clearing after reset.
`default_nettype none
`include "grid_laplacian_smooth_macros.svh"
module grid_laplacian_smooth
   import gls_pkg::*;
#(
   parameter int MaxPoints = MaxPointsDef,
   parameter int MaxDim    = MaxDimDef
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // x_coord [31:0], y_coord [63:32], z_coord [95:64], point_valid [96], zero [103:97]
   input  wire logic [103:0] req_tdata,
   // kind [0]
   input  wire logic [0:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // out_x [31:0], out_y [63:32], out_z [95:64], out_valid [96], zero [103:97]
   output logic [103:0]      rsp_tdata,
   output logic              rsp_tlast,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [3:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int IW     = $clog2(MaxPoints + 1);
   localparam int AW     = $clog2(2 * MaxPoints);
   localparam int DW     = $clog2(MaxDim + 1);
   localparam int ColCap = (MaxDim < MaxPoints) ? MaxDim : MaxPoints;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_SMOOTH = 2'b10
   } state_type;

   state_type     state_ff, state_in;
   logic [6:0]    rows_ff, rows_in, cols_ff, cols_in;
   logic [7:0]    passes_ff, passes_in;
   logic [7:0]    passes_left_ff, passes_left_in;
   logic          start_ff, start_in;
   logic          bank_ff, bank_in;
   logic [IW-1:0] load_idx_ff, load_idx_in, read_idx_ff, read_idx_in;
   logic          rd_pend_ff, rd_pend_in;
   logic          last_d_ff, last_d_in;
   logic          rsp_valid_ff, rsp_valid_in;
   point_type     rsp_pt_ff, rsp_pt_in;
   logic          rsp_ok_ff, rsp_ok_in;
   logic          rsp_last_ff, rsp_last_in;

   logic [DW-1:0]   row_cap [1 << DW];
   logic [DW-1:0]   rows_c, cols_c, rows_g;
   logic [DW-1:0]   cols_g_w;
   logic [2*DW-1:0] prod;
   logic [IW-1:0]   npts, li, ri, li_next;
   logic            csr_wr;
   reg_index_type   csr_idx;
   logic            accept, load_we, read_re;
   point_type       load_pt, rd_data, eng_wr_data, wr_data;
   logic [AW-1:0]   load_addr, read_addr, eng_rd_addr, eng_wr_addr, wr_addr, rd_addr;
   logic            eng_rd_en, eng_wr_en, wr_en, rd_en;
   pass_ctl_type    ctl;
   pass_stat_type   stat;

   assign row_cap[0] = DW'(MaxDim);
   for (genvar Ci = 1; Ci < (1 << DW); Ci++) begin : g_cap
      localparam int Quo = MaxPoints / Ci;
      assign row_cap[Ci] = (Quo > MaxDim) ? DW'(MaxDim) : DW'(Quo);
   end

   always_comb begin
      if (rows_ff == '0) begin
         rows_c = DW'(1);
      end else if (int'(rows_ff) > MaxDim) begin
         rows_c = DW'(MaxDim);
      end else begin
         rows_c = DW'(rows_ff);
      end
      if (cols_ff == '0) begin
         cols_c = DW'(1);
      end else if (int'(cols_ff) > ColCap) begin
         cols_c = DW'(ColCap);
      end else begin
         cols_c = DW'(cols_ff);
      end
      rows_g = (rows_c > row_cap[cols_c]) ? row_cap[cols_c] : rows_c;
   end

   assign cols_g_w = cols_c;
   assign prod     = (2*DW)'(rows_g) * (2*DW)'(cols_g_w);
   assign npts     = IW'(prod);

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      unique case (csr_idx)
         RegRows:   csr_prdata = {25'd0, rows_ff};
         RegCols:   csr_prdata = {25'd0, cols_ff};
         RegPasses: csr_prdata = {24'd0, passes_ff};
         default:   csr_prdata = '0;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE) && !rd_pend_ff && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign load_we    = accept && !req_tuser[0];
   assign read_re    = accept && req_tuser[0];

   assign li      = (load_idx_ff >= npts) ? '0 : load_idx_ff;
   assign ri      = (read_idx_ff >= npts) ? '0 : read_idx_ff;
   assign li_next = li + 1'b1;

   assign load_pt   = '{z: req_tdata[95:64], y: req_tdata[63:32], x: req_tdata[31:0],
                        vld: req_tdata[96]};
   assign load_addr = bank_ff ? AW'(li) + AW'(MaxPoints) : AW'(li);
   assign read_addr = bank_ff ? AW'(ri) + AW'(MaxPoints) : AW'(ri);

   assign wr_en   = load_we || eng_wr_en;
   assign wr_addr = load_we ? load_addr : eng_wr_addr;
   assign wr_data = load_we ? load_pt : eng_wr_data;
   assign rd_en   = read_re || eng_rd_en;
   assign rd_addr = read_re ? read_addr : eng_rd_addr;

   always_comb begin
      state_in       = state_ff;
      rows_in        = rows_ff;
      cols_in        = cols_ff;
      passes_in      = passes_ff;
      passes_left_in = passes_left_ff;
      start_in       = 1'b0;
      bank_in        = bank_ff;
      load_idx_in    = load_idx_ff;
      read_idx_in    = read_idx_ff;
      rd_pend_in     = read_re;
      last_d_in      = last_d_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_pt_in      = rsp_pt_ff;
      rsp_ok_in      = rsp_ok_ff;
      rsp_last_in    = rsp_last_ff;

      if (csr_wr) begin
         unique case (csr_idx)
            RegRows:   rows_in   = csr_pwdata[6:0];
            RegCols:   cols_in   = csr_pwdata[6:0];
            RegPasses: passes_in = csr_pwdata[7:0];
            default:   rows_in   = rows_ff;
         endcase
      end

      if (load_we) begin
         if (li_next >= npts) begin
            load_idx_in = '0;
            read_idx_in = '0;
            if (passes_ff != '0) begin
               state_in       = ST_SMOOTH;
               start_in       = 1'b1;
               passes_left_in = passes_ff;
            end
         end else begin
            load_idx_in = li_next;
         end
      end

      if (read_re) begin
         last_d_in   = ri == IW'(npts - 1'b1);
         read_idx_in = ((ri + 1'b1) >= npts) ? '0 : ri + 1'b1;
      end

      if (rd_pend_ff) begin
         rsp_valid_in = 1'b1;
         rsp_pt_in    = rd_data;
         rsp_ok_in    = point_ok(rd_data);
         rsp_last_in  = last_d_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: state_in = state_in;
         ST_SMOOTH: begin
            if (stat.done) begin
               bank_in = !bank_ff;
               if (passes_left_ff == 8'd1) begin
                  state_in = ST_IDLE;
               end else begin
                  passes_left_in = passes_left_ff - 1'b1;
                  start_in       = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rows_ff        <= 7'd64;
         cols_ff        <= 7'd64;
         passes_ff      <= 8'd1;
         passes_left_ff <= '0;
         start_ff       <= 1'b0;
         bank_ff        <= 1'b0;
         load_idx_ff    <= '0;
         read_idx_ff    <= '0;
         rd_pend_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rows_ff        <= rows_in;
         cols_ff        <= cols_in;
         passes_ff      <= passes_in;
         passes_left_ff <= passes_left_in;
         start_ff       <= start_in;
         bank_ff        <= bank_in;
         load_idx_ff    <= load_idx_in;
         read_idx_ff    <= read_idx_in;
         rd_pend_ff     <= rd_pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      last_d_ff   <= last_d_in;
      rsp_pt_ff   <= rsp_pt_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign ctl.start    = start_ff;
   assign ctl.src_bank = bank_ff;

   gls_store #(.Depth(2 * MaxPoints)) u_store (
      .clock,
      .wr_en,
      .wr_addr,
      .wr_data,
      .rd_en,
      .rd_addr,
      .rd_data
   );

   gls_pass #(.MaxPoints(MaxPoints), .MaxDim(MaxDim)) u_pass (
      .clock,
      .reset,
      .ctl,
      .rows    (rows_g),
      .cols    (cols_g_w),
      .npts,
      .rd_en   (eng_rd_en),
      .rd_addr (eng_rd_addr),
      .rd_data,
      .wr_en   (eng_wr_en),
      .wr_addr (eng_wr_addr),
      .wr_data (eng_wr_data),
      .stat
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ok_ff, rsp_pt_ff.z, rsp_pt_ff.y, rsp_pt_ff.x};
   assign rsp_tlast  = rsp_last_ff;

   `GLS_ASSERT_NEXT(a_read_lands, clock, reset, rd_pend_ff, rsp_valid_ff, "read data not captured")
   `GLS_ASSERT_IMPL(a_one_writer, clock, reset, load_we, !eng_wr_en, "load and pass write collide")
   `GLS_ASSERT_IMPL(a_pass_count, clock, reset, start_ff, passes_left_ff != 8'd0, "pass with no count")
   `GLS_ASSERT_IMPL(a_engine_idle, clock, reset, state_ff == ST_IDLE, !stat.busy, "engine busy while idle")

endmodule
`default_nettype wire
